FILE: rtl/core/assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/itbd_pkg.sv
package itbd_pkg;

    // radix limits and the one radix that prints a sign
    localparam logic [4:0] BASE_MIN = 5'd2;
    localparam logic [4:0] BASE_MAX = 5'd16;
    localparam logic [4:0] BASE_DEC = 5'd10;

    // quotient bits resolved per divide cycle
    localparam int STEP_BITS = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NONE  = 8'h00;
    // gap between '9' and 'A'
    localparam logic [7:0] ALPHA_GAP  = 8'h41 - 8'h39 - 8'h01;
    localparam logic [3:0] DEC_DIGIT_MAX = 4'd9;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_error;
        logic emit_sign;
        logic emit_digit;
    } itbd_cmd_t;

    typedef struct packed {
        logic base_ok;
        logic chunk_last;
        logic quot_zero;
        logic sign_needed;
        logic digit_last;
        logic out_free;
    } itbd_status_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ch;
        ch = CHAR_ZERO + {4'b0000, d};
        if (d > DEC_DIGIT_MAX)
        begin
            ch = ch + ALPHA_GAP;
        end
        return ch;
    endfunction

endpackage

FILE: rtl/core/integer_to_base_digits.sv
// Integer to ASCII digit stream, radix 2 to 16. One item (value, base) is
// taken while the block is idle; the digits then come out most significant
// first, one item per character, with last set on the final one. Digits ten
// to fifteen print as 'A' to 'F'; a negative value gets a leading '-' in
// radix 10 only, every other radix prints the unsigned magnitude, and the
// most negative value prints its true magnitude. A radix outside 2..16
// gives one item with error and last set and character zero. Timing: each
// digit is a restoring division by the radix, 4 quotient bits a cycle,
// then the characters follow one per cycle when the output side takes
// every item. The idle state and the sign state come on top of the digit
// work, with or without a sign; the worst case is base 2 of the minimum
// value. The next item is taken once the last character is in the output
// register.
`include "assert_macros.svh"

module integer_to_base_digits
    import itbd_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [4:0]            base,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            character,
    output logic                  last,
    output logic                  error
);

    itbd_cmd_t    cmd;
    itbd_status_t status;

    // sequencer: idle, error item or divide per digit, optional sign, then drain digits
    itbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // divider, digit stack and the output register
    itbd_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .base      (base),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last),
        .error     (error)
    );

    // an error item stands alone
    `ASSERT_IMPL(a_error_alone, clk, rst_n, out_valid && error, last && (character == CHAR_NONE))
    // the sign is never the final character
    `ASSERT_IMPL(a_sign_not_last, clk, rst_n, out_valid && !error && (character == CHAR_MINUS), !last)
    // block is busy right after it takes an item
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // emitting the final digit frees the input side
    `ASSERT_NEXT(a_idle_after_last, clk, rst_n, cmd.emit_digit && status.digit_last, in_ready)

endmodule

FILE: rtl/core/itbd_ctrl.sv
module itbd_ctrl
    import itbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  itbd_status_t status,
    output itbd_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ERROR = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.base_ok ? ST_DIV : ST_ERROR;
                end
            end
            ST_ERROR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_error = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.chunk_last && status.quot_zero)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (!status.sign_needed)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.digit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/itbd_datapath.sv
module itbd_datapath
    import itbd_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [4:0]            base,
    input  itbd_cmd_t             cmd,
    output itbd_status_t          status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            character,
    output logic                  last,
    output logic                  error
);

    localparam int CHUNKS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD     = CHUNKS * STEP_BITS;
    localparam int CHUNK_W = $clog2(CHUNKS);
    localparam int CNT_W   = $clog2(VALUE_BITS + 1);

    logic [PAD-1:0]              work_reg;
    logic [PAD-1:0]              work_next;
    logic [3:0]                  rem_reg;
    logic [3:0]                  rem_next;
    logic [4:0]                  radix_reg;
    logic                        neg_reg;
    logic [CHUNK_W-1:0]          chunk_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [VALUE_BITS-1:0][3:0]  stack_reg;
    logic                        out_valid_reg;
    logic [7:0]                  char_reg;
    logic                        last_reg;
    logic                        error_reg;

    logic [VALUE_BITS-1:0]       mag;
    logic                        chunk_last;
    logic                        emit_any;

    // two's complement magnitude, the minimum value wraps to its true size
    assign mag        = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
    assign chunk_last = (chunk_reg == CHUNK_W'(CHUNKS - 1));
    assign emit_any   = cmd.emit_error | cmd.emit_sign | cmd.emit_digit;

    // restoring division, STEP_BITS quotient bits per cycle
    always_comb
    begin
        logic [4:0] trial;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            trial     = {rem_next, work_next[PAD-1]};
            work_next = {work_next[PAD-2:0], 1'b0};
            if (trial >= radix_reg)
            begin
                trial        = trial - radix_reg;
                work_next[0] = 1'b1;
            end
            rem_next = trial[3:0];
        end
    end

    assign status.base_ok     = (base inside {[BASE_MIN:BASE_MAX]});
    assign status.chunk_last  = chunk_last;
    assign status.quot_zero   = (work_next == '0);
    assign status.sign_needed = neg_reg && (radix_reg == BASE_DEC);
    assign status.digit_last  = (cnt_reg == CNT_W'(1));
    assign status.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg  <= PAD'(mag);
            rem_reg   <= '0;
            radix_reg <= base;
            neg_reg   <= value[VALUE_BITS-1];
            chunk_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            work_reg <= work_next;
            if (chunk_last)
            begin
                // digit done: push it, start next division with zero remainder
                chunk_reg <= '0;
                rem_reg   <= '0;
                stack_reg <= {stack_reg[VALUE_BITS-2:0], rem_next};
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
            else
            begin
                chunk_reg <= chunk_reg + CHUNK_W'(1);
                rem_reg   <= rem_next;
            end
        end
        else if (cmd.emit_digit)
        begin
            // most significant digit sits on top of the stack
            stack_reg <= {4'b0000, stack_reg[VALUE_BITS-1:1]};
            cnt_reg   <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_error)
        begin
            char_reg  <= CHAR_NONE;
            last_reg  <= 1'b1;
            error_reg <= 1'b1;
        end
        else if (cmd.emit_sign)
        begin
            char_reg  <= CHAR_MINUS;
            last_reg  <= 1'b0;
            error_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg  <= digit_char(stack_reg[0]);
            last_reg  <= status.digit_last;
            error_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_any)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule
